// ===== rtl/height_map_neighbour_smoother_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the height map smoother
// Same-cycle and next-cycle implication checks, reset-gated.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_MAP_NEIGHBOUR_SMOOTHER_TOP_ASSERT_SVH
`define HEIGHT_MAP_NEIGHBOUR_SMOOTHER_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define HMNS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define HMNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hmns_pkg.sv =====
// ----------------------------------------------------------------------------
// hmns_pkg
// Shared sizes, codes and helpers for the height map smoother.
// ----------------------------------------------------------------------------
package hmns_pkg;

  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int MAX_R = 7;

  localparam int CW     = $clog2(MAX_W);          // column index width
  localparam int RW     = $clog2(MAX_H);          // row index width
  localparam int AW     = $clog2(MAX_W * MAX_H);  // store address width
  localparam int DW     = 16;                     // sample width
  localparam int DIMW   = 7;                      // map_width / map_height width
  localparam int RADW   = 3;                      // window_radius width
  localparam int CFGW   = 7;                      // config data width
  localparam int WIN_N  = (2 * MAX_R + 1) * (2 * MAX_R + 1);
  localparam int SUM_W  = DW + $clog2(WIN_N);     // neighbour sum width
  localparam int N_W    = $clog2(WIN_N);          // neighbour count width

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_SMOOTH = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col);
    cell_addr = AW'(row) * AW'(MAX_W) + AW'(col);
  endfunction

endpackage

// ===== rtl/height_map_neighbour_smoother_top.sv =====
// ----------------------------------------------------------------------------
// height_map_neighbour_smoother_top
// Height map store with single-cell write/read and clipped box-mean
// smoothing passes, run by a sequencer around one accumulator and one
// iterative divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i / in_stall_o | func_i col_i row_i sample_in_i pass_count_i
//  out     | source    | out_valid_o / out_stall_i | sample_out_o status_o
//  cfg     | sink      | cfg_we_i                | cfg_index_i cfg_data_i
//
// Write, read with bad coordinate, unused code, zero-pass smooth: result
// registered at the accepting edge. In-range read: result in the next cycle
// (registered RAM read).
// Smooth: per pass every one of the 64x64 cells is visited. A copied cell
// goes through a center fetch and a write; an averaged cell fetches the
// center, reads each neighbour and skips the center through the single
// read port, starts the 24-step divider, waits for its done flag, then
// writes.
// Two stores ping-pong; each pass writes the other one and flips them.
// Reset clears control and config (64, 64, 1); the stores are not cleared.
// Input is taken only while idle and with the result register free or
// draining; a stalled result just holds.
// ----------------------------------------------------------------------------
`include "height_map_neighbour_smoother_top_assert.svh"

module height_map_neighbour_smoother_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        func_i,
  input  logic [hmns_pkg::CW-1:0]           col_i,
  input  logic [hmns_pkg::RW-1:0]           row_i,
  input  logic signed [hmns_pkg::DW-1:0]    sample_in_i,
  input  logic [7:0]                        pass_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hmns_pkg::DW-1:0]    sample_out_o,
  output logic                              status_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [hmns_pkg::CFGW-1:0]         cfg_data_i
);

  localparam int CW   = hmns_pkg::CW;
  localparam int RW   = hmns_pkg::RW;
  localparam int AW   = hmns_pkg::AW;
  localparam int DW   = hmns_pkg::DW;
  localparam int DIMW = hmns_pkg::DIMW;
  localparam int RADW = hmns_pkg::RADW;
  localparam int SW   = hmns_pkg::SUM_W;
  localparam int NW   = hmns_pkg::N_W;
  localparam int PW   = 2 * DIMW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDRESP = 4'd1;
  localparam logic [3:0] S_CELL   = 4'd2;
  localparam logic [3:0] S_CWAIT  = 4'd3;
  localparam logic [3:0] S_WADDR  = 4'd4;
  localparam logic [3:0] S_WDATA  = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;

  // config
  logic [DIMW-1:0] map_width_q, map_height_q;
  logic [RADW-1:0] window_radius_q;
  logic [DIMW-1:0] w_eff, h_eff;
  logic [RADW-1:0] r_eff;

  // sequencer
  logic [3:0]         state_q, state_d;
  logic               cur_q, cur_d;
  logic [7:0]         passes_q, passes_d;
  logic [CW-1:0]      cx_q, cx_d, nx_q, nx_d, x0_q, x0_d, x1_q, x1_d;
  logic [RW-1:0]      cy_q, cy_d, ny_q, ny_d, y0_q, y0_d, y1_q, y1_d;
  logic [NW-1:0]      n_q, n_d;
  logic               avg_q, avg_d;
  logic signed [DW-1:0] c_q, c_d;
  logic signed [SW-1:0] sum_q, sum_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [DW-1:0] sample_q, sample_d;
  logic               status_q, status_d;

  // memory side
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en, wr_other;
  logic [DW-1:0]      wr_data;
  logic [DW-1:0]      rdata_a, rdata_b;
  logic signed [DW-1:0] rdata;

  // divider
  logic                 div_start, div_busy, div_done;
  logic signed [SW-1:0] div_q;

  // window bound logic
  logic               accept, in_range;
  logic [CW-1:0]      bx0, bx1;
  logic [RW-1:0]      by0, by1;
  logic [DIMW-1:0]    xr, yr, wl, hl;
  logic [DIMW-1:0]    dx, dy;
  logic [PW-1:0]      n_full;
  logic               in_area;
  logic               win_last, is_center;
  logic signed [DW:0] half_sum;

  // assertion helpers
  logic               rd_accept, pass_end;

  assign w_eff = (map_width_q  > DIMW'(hmns_pkg::MAX_W)) ? DIMW'(hmns_pkg::MAX_W) : map_width_q;
  assign h_eff = (map_height_q > DIMW'(hmns_pkg::MAX_H)) ? DIMW'(hmns_pkg::MAX_H) : map_height_q;
  assign r_eff = (window_radius_q > RADW'(hmns_pkg::MAX_R)) ? RADW'(hmns_pkg::MAX_R)
                                                            : window_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q     <= DIMW'(64);
      map_height_q    <= DIMW'(64);
      window_radius_q <= RADW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hmns_pkg::CFG_WIDTH:  map_width_q     <= cfg_data_i[DIMW-1:0];
        hmns_pkg::CFG_HEIGHT: map_height_q    <= cfg_data_i[DIMW-1:0];
        hmns_pkg::CFG_RADIUS: window_radius_q <= cfg_data_i[RADW-1:0];
        default: ;
      endcase
    end
  end

  // clipped window of the current cell
  always_comb begin
    bx0     = (cx_q > CW'(r_eff)) ? cx_q - CW'(r_eff) : '0;
    by0     = (cy_q > RW'(r_eff)) ? cy_q - RW'(r_eff) : '0;
    xr      = DIMW'(cx_q) + DIMW'(r_eff);
    yr      = DIMW'(cy_q) + DIMW'(r_eff);
    wl      = w_eff - DIMW'(1);
    hl      = h_eff - DIMW'(1);
    bx1     = (xr < wl) ? xr[CW-1:0] : wl[CW-1:0];
    by1     = (yr < hl) ? yr[RW-1:0] : hl[RW-1:0];
    dx      = DIMW'(bx1) - DIMW'(bx0) + DIMW'(1);
    dy      = DIMW'(by1) - DIMW'(by0) + DIMW'(1);
    n_full  = PW'(dx) * PW'(dy) - PW'(1);
    in_area = (DIMW'(cx_q) < w_eff) && (DIMW'(cy_q) < h_eff);
  end

  assign rdata     = cur_q ? $signed(rdata_b) : $signed(rdata_a);
  assign accept    = in_valid_i && !in_stall_o;
  assign in_range  = (DIMW'(col_i) < w_eff) && (DIMW'(row_i) < h_eff);
  assign win_last  = (nx_q == x1_q) && (ny_q == y1_q);
  assign is_center = (nx_q == cx_q) && (ny_q == cy_q);
  // floor((c + mean) / 2); the mean is signed and must sign-extend
  assign half_sum  = (DW+1)'(c_q) + (DW+1)'($signed(div_q[DW-1:0]));

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    passes_d    = passes_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    y0_d        = y0_q;
    y1_d        = y1_q;
    n_d         = n_q;
    avg_d       = avg_q;
    c_d         = c_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    sample_d    = sample_q;
    status_d    = status_q;
    rd_addr     = hmns_pkg::cell_addr(ny_q, nx_q);
    wr_addr     = hmns_pkg::cell_addr(cy_q, cx_q);
    wr_en       = 1'b0;
    wr_other    = 1'b1;
    wr_data     = avg_q ? half_sum[DW:1] : c_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_addr  = hmns_pkg::cell_addr(row_i, col_i);
        wr_addr  = hmns_pkg::cell_addr(row_i, col_i);
        wr_data  = sample_in_i;
        wr_other = 1'b0;
        if (accept) begin
          sample_d = '0;
          status_d = 1'b0;
          case (func_i)
            hmns_pkg::FN_WRITE: begin
              wr_en       = in_range;
              status_d    = !in_range;
              out_valid_d = 1'b1;
            end
            hmns_pkg::FN_READ: begin
              if (in_range) begin
                state_d = S_RDRESP;
              end else begin
                status_d    = 1'b1;
                out_valid_d = 1'b1;
              end
            end
            hmns_pkg::FN_SMOOTH: begin
              if (pass_count_i == '0) begin
                out_valid_d = 1'b1;
              end else begin
                passes_d = pass_count_i;
                cx_d     = '0;
                cy_d     = '0;
                state_d  = S_CELL;
              end
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      S_RDRESP: begin
        sample_d    = rdata;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_CELL: begin
        rd_addr = hmns_pkg::cell_addr(cy_q, cx_q);
        x0_d    = bx0;
        x1_d    = bx1;
        y0_d    = by0;
        y1_d    = by1;
        n_d     = NW'(n_full);
        avg_d   = in_area && (r_eff != '0) && (n_full != '0);
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        c_d   = rdata;
        nx_d  = x0_q;
        ny_d  = y0_q;
        sum_d = '0;
        state_d = avg_q ? S_WADDR : S_WRITE;
      end
      S_WADDR: begin
        if (!is_center) begin
          state_d = S_WDATA;
        end else if (win_last) begin
          state_d = S_DIV;
        end else if (nx_q == x1_q) begin
          nx_d = x0_q;
          ny_d = ny_q + RW'(1);
        end else begin
          nx_d = nx_q + CW'(1);
        end
      end
      S_WDATA: begin
        sum_d = sum_q + SW'(rdata);
        if (win_last) begin
          state_d = S_DIV;
        end else begin
          state_d = S_WADDR;
          if (nx_q == x1_q) begin
            nx_d = x0_q;
            ny_d = ny_q + RW'(1);
          end else begin
            nx_d = nx_q + CW'(1);
          end
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        state_d = S_CELL;
        if (cx_q == CW'(hmns_pkg::MAX_W - 1)) begin
          cx_d = '0;
          if (cy_q == RW'(hmns_pkg::MAX_H - 1)) begin
            // pass done: flip stores
            cy_d     = '0;
            cur_d    = !cur_q;
            passes_d = passes_q - 8'd1;
            if (passes_q == 8'd1) begin
              sample_d    = '0;
              status_d    = 1'b0;
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end else begin
            cy_d = cy_q + RW'(1);
          end
        end else begin
          cx_d = cx_q + CW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= 1'b0;
      passes_q    <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      passes_q    <= passes_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q     <= nx_d;
    ny_q     <= ny_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y0_q     <= y0_d;
    y1_q     <= y1_d;
    n_q      <= n_d;
    avg_q    <= avg_d;
    c_q      <= c_d;
    sum_q    <= sum_d;
    sample_q <= sample_d;
    status_q <= status_d;
  end

  // reads always hit the live store; smoothing writes the other one
  hmns_ram #(.WIDTH(DW), .DEPTH(hmns_pkg::MAX_W * hmns_pkg::MAX_H)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wr_en && ((cur_q ^ wr_other) == 1'b0)),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata_a)
  );

  hmns_ram #(.WIDTH(DW), .DEPTH(hmns_pkg::MAX_W * hmns_pkg::MAX_H)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (wr_en && ((cur_q ^ wr_other) == 1'b1)),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rdata_b)
  );

  hmns_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_stall_o   = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign status_o     = status_q;

  assign rd_accept = accept && (func_i == hmns_pkg::FN_READ) && in_range;
  assign pass_end  = (state_q == S_WRITE) && (cx_q == CW'(hmns_pkg::MAX_W - 1))
                     && (cy_q == RW'(hmns_pkg::MAX_H - 1));

  `HMNS_ASSERT_SAME(a_accept_idle, clk_i, rst_ni, accept, state_q == S_IDLE, "taken while busy")
  `HMNS_ASSERT_NEXT(a_read_resp, clk_i, rst_ni, rd_accept, state_q == S_RDRESP, "read not answered")
  `HMNS_ASSERT_SAME(a_div_start, clk_i, rst_ni, div_start, !div_busy, "divider restarted")
  `HMNS_ASSERT_NEXT(a_pass_flip, clk_i, rst_ni, pass_end, cur_q != $past(cur_q), "store not flipped")

endmodule

// ===== rtl/hmns_ram.sv =====
// ----------------------------------------------------------------------------
// hmns_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/hmns_div.sv =====
// ----------------------------------------------------------------------------
// hmns_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module hmns_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [hmns_pkg::SUM_W-1:0] dividend_i,
  input  logic [hmns_pkg::N_W-1:0]         divisor_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [hmns_pkg::SUM_W-1:0] quotient_o
);

  localparam int SW = hmns_pkg::SUM_W;
  localparam int NW = hmns_pkg::N_W;
  localparam int KW = $clog2(SW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          neg_q, neg_d;
  logic [SW-1:0] mag_q, mag_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] dvs_q, dvs_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [NW:0]   trial;
  logic          fits;

  always_comb begin
    trial  = {rem_q, mag_q[SW-1]};
    fits   = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[SW-1];
      mag_d  = dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = KW'(SW);
    end else if (busy_q) begin
      rem_d = fits ? NW'(trial - {1'b0, dvs_q}) : trial[NW-1:0];
      mag_d = {mag_q[SW-2:0], fits};
      cnt_d = cnt_q - KW'(1);
      if (cnt_q == KW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule
